@@ design/assert_macros.svh @@
// Assertion macros shared by the timer bank RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ design/arb_pkg.sv @@
// Types and constants of the auto-reload timer bank.
// No dependencies.
`default_nettype none

package arb_pkg;

    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 32;
    localparam int MASK_W   = 8;
    localparam int ID_W     = 3;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_REQUEST    = 3'd1,
        OP_SET_PERIOD = 3'd2,
        OP_RESTART    = 3'd3,
        OP_RELEASE    = 3'd4
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ID_W-1:0]     slot_id;
        logic [PERIOD_W-1:0] period_ticks;
    } t_cmd;

    typedef struct packed {
        logic [MASK_W-1:0]  fired_mask;
        logic               granted;
        logic [ID_W-1:0]    granted_slot;
        logic [COUNT_W-1:0] tick_count;
    } t_res;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remain;
    } t_slot;

endpackage

`default_nettype wire

@@ design/auto_reload_timer_bank.sv @@
// Auto-reload timer bank: a 32-bit tick count and NUM_SLOTS countdown slots.
// Depends on arb_pkg, arb_ram and assert_macros.svh.
//
// A command is taken when start is high and busy is low; its one result is shown
// on o_res, with o_done high for a single cycle, and cannot be held off. Slot state
// lives in one RAM swept by a single decrement-and-compare unit, one slot per
// cycle. After a command is taken, busy stays high while a tick sweeps every slot,
// while a request searches for a free slot, and while a set period, restart or
// release is applied, with an extra RAM write on a restart of a slot in use; o_done
// rises in the cycle in which busy falls.
`default_nettype none
`include "assert_macros.svh"

module auto_reload_timer_bank import arb_pkg::*; #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_res      o_res
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = SW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_REQ,
        S_APPLY,
        S_RESTART_WR,
        S_FINISH
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic [SW-1:0]        r_pslot;
    logic [NUM_SLOTS-1:0] r_in_use;
    logic [COUNT_W-1:0]   r_count;
    logic [MASK_W-1:0]    r_fired;
    logic                 r_grant;
    logic [ID_W-1:0]      r_gslot;
    logic                 r_done;
    t_res                 r_res;

    logic                w_we;
    logic [SW-1:0]       w_waddr;
    t_slot               w_wdata;
    logic [SW-1:0]       w_raddr;
    t_slot               w_rdata;
    logic [PERIOD_W-1:0] w_dec;
    logic                w_expire;
    logic                w_in_range;
    logic [SW-1:0]       w_cslot;
    logic [SW-1:0]       w_ridx;

    arb_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ridx     = r_idx[SW-1:0];
    assign w_in_range = (7'(r_cmd.slot_id) < 7'(NUM_SLOTS));
    assign w_cslot    = SW'(r_cmd.slot_id);
    assign w_dec      = w_rdata.remain - PERIOD_W'(1);
    assign w_expire   = r_pend && r_in_use[r_pslot] && (w_dec == '0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cslot;
        w_wdata = '{period: r_cmd.period_ticks, remain: r_cmd.period_ticks};
        w_raddr = w_ridx;
        case (r_state)
            S_TICK: begin
                w_we    = r_pend && r_in_use[r_pslot];
                w_waddr = r_pslot;
                w_wdata = '{period: w_rdata.period,
                            remain: w_expire ? w_rdata.period : w_dec};
            end
            S_REQ: begin
                w_we    = !r_in_use[w_ridx];
                w_waddr = w_ridx;
            end
            S_APPLY: begin
                w_we    = w_in_range && (r_cmd.opcode == OP_SET_PERIOD);
                w_raddr = w_cslot;
            end
            S_RESTART_WR: begin
                w_we    = 1'b1;
                w_wdata = '{period: w_rdata.period, remain: w_rdata.period};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_fired <= '0;
                        r_grant <= 1'b0;
                        r_gslot <= '0;
                        case (i_cmd.opcode)
                            OP_TICK: begin
                                r_count <= r_count + COUNT_W'(1);
                                r_state <= S_TICK;
                            end
                            OP_REQUEST: begin
                                r_state <= (i_cmd.period_ticks != '0) ? S_REQ : S_FINISH;
                            end
                            OP_SET_PERIOD, OP_RESTART, OP_RELEASE: begin
                                r_state <= S_APPLY;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    if (w_expire) begin
                        r_fired <= r_fired | (MASK_W'(1) << r_pslot);
                    end
                    if (r_idx == CW'(NUM_SLOTS)) begin
                        r_pend  <= 1'b0;
                        r_state <= S_FINISH;
                    end else begin
                        r_pend  <= 1'b1;
                        r_pslot <= w_ridx;
                        r_idx   <= r_idx + CW'(1);
                    end
                end
                S_REQ: begin
                    if (!r_in_use[w_ridx]) begin
                        r_in_use[w_ridx] <= 1'b1;
                        r_grant          <= 1'b1;
                        r_gslot          <= ID_W'(w_ridx);
                        r_state          <= S_FINISH;
                    end else if (r_idx == CW'(NUM_SLOTS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_APPLY: begin
                    r_state <= S_FINISH;
                    if (w_in_range) begin
                        case (r_cmd.opcode)
                            OP_SET_PERIOD: begin
                                r_in_use[w_cslot] <= (r_cmd.period_ticks != '0);
                            end
                            OP_RELEASE: begin
                                r_in_use[w_cslot] <= 1'b0;
                            end
                            OP_RESTART: begin
                                if (r_in_use[w_cslot]) begin
                                    r_state <= S_RESTART_WR;
                                end
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_RESTART_WR: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_res   <= '{fired_mask:   r_fired,
                                 granted:      r_grant,
                                 granted_slot: r_gslot,
                                 tick_count:   r_count};
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_CLK(a_done_after_busy, o_done |-> $past(busy), "result without work")
    `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "request taken but not busy")
    `ASSERT_NEVER(a_fired_tick_only,
        o_done && (r_cmd.opcode != OP_TICK) && (o_res.fired_mask != '0),
        "fired mask on a non-tick request")

endmodule

`default_nettype wire

@@ design/arb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
